// ===== rtl/core/lpsa_pkg.sv =====
// lpsa_pkg: shared constants and controller/datapath interface structs
// for the linear probe slot allocator; no dependencies
package lpsa_pkg;

    localparam int ID_W      = 31;    // request_id width
    localparam int SLOT_W    = 13;    // slot output width
    localparam int CFG_W     = 14;    // table_size register width
    localparam int WORD_W    = 32;    // bitmap bits per memory row
    localparam int WORD_SH   = 5;     // log2 of WORD_W
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 14'd8192;

    // register index as decoded from paddr[2]
    localparam logic REG_TABLE_SIZE = 1'b0;

    typedef struct packed {
        logic clr_wr;     // clear one bitmap row
        logic start;      // latch request, begin divide
        logic div_step;   // one restoring divide step
        logic rd_en;      // read bitmap row at probe position
        logic eval;       // examine row, allocate or advance
        logic load_out;   // move result into output register
    } lpsa_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic hit;
        logic exhausted;
        logic out_busy;
    } lpsa_stat_t;

endpackage

// ===== rtl/core/linear_probe_slot_allocator.sv =====
// Linear probe slot allocator: each request takes its home slot as
// request_id modulo the size in use (table_size clamped to 1..MAX_SLOTS) and
// claims the first free slot from there, wrapping at that size; slots are
// freed only by reset, and a table with no free slot in use returns table_full
// with slot 0 and no change. One request is in work at a time: it is accepted,
// a bit-serial remainder unit forms the home slot, then each 32-bit bitmap row
// from the probe position is read and examined (one row when the home row has
// a free slot at or above the home slot, at most ceil(size/32)+1 rows), and
// the result is loaded into the output register, which waits while the previous
// request's result is still unaccepted. After reset the bitmap memory is
// cleared one row a cycle, all ceil(MAX_SLOTS/32) rows (256 at the default),
// before the first request is taken; APB writes are taken throughout.
// Depends on lpsa_pkg, lpsa_ctrl, lpsa_datapath, lpsa_ram.
module linear_probe_slot_allocator #(
    parameter int MAX_SLOTS = 8192
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,   // [30:0] request_id, [31] zero
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,   // [12:0] slot, [15:13] zero
    output logic [0:0]                        m_axis_tuser,   // [0] table_full
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpsa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lpsa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lpsa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    logic [lpsa_pkg::CFG_W-1:0]  table_size_reg;
    logic                        cfg_wr;
    lpsa_pkg::lpsa_cmd_t         cmd;
    lpsa_pkg::lpsa_stat_t        st;
    logic [lpsa_pkg::SLOT_W-1:0] out_slot;
    logic                        out_full;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == lpsa_pkg::REG_TABLE_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= lpsa_pkg::TABLE_SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            table_size_reg <= pwdata[lpsa_pkg::CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == lpsa_pkg::REG_TABLE_SIZE)
                  ? lpsa_pkg::APB_DATA_W'(table_size_reg) : '0;

    lpsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lpsa_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .table_size (table_size_reg),
        .request_id (s_axis_tdata[lpsa_pkg::ID_W-1:0]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_slot   (out_slot),
        .out_full   (out_full)
    );

    assign m_axis_tdata = 16'(out_slot);
    assign m_axis_tuser = out_full;

endmodule

// ===== rtl/core/lpsa_ram.sv =====
// lpsa_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module lpsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/lpsa_ctrl.sv =====
// lpsa_ctrl: sequencing state machine for the slot allocator
// depends on lpsa_pkg (command and status structs)
module lpsa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lpsa_pkg::lpsa_stat_t st,
    output lpsa_pkg::lpsa_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DIV   = 6'b000100,
        S_READ  = 6'b001000,
        S_EVAL  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (st.hit || st.exhausted)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                if (!st.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/lpsa_datapath.sv =====
// lpsa_datapath: serial modulo, word-wide bitmap probe and result registers
// depends on lpsa_pkg and lpsa_ram
module lpsa_datapath #(
    parameter int MAX_SLOTS = 8192
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpsa_pkg::lpsa_cmd_t           cmd,
    output lpsa_pkg::lpsa_stat_t          st,
    input  logic [lpsa_pkg::CFG_W-1:0]    table_size,
    input  logic [lpsa_pkg::ID_W-1:0]     request_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lpsa_pkg::SLOT_W-1:0]   out_slot,
    output logic                          out_full
);

    localparam int SIZE_W = $clog2(MAX_SLOTS + 1);
    localparam int CW     = (SIZE_W > lpsa_pkg::WORD_SH + 1) ? SIZE_W : lpsa_pkg::WORD_SH + 1;
    localparam int ROWS   = (MAX_SLOTS + lpsa_pkg::WORD_W - 1) / lpsa_pkg::WORD_W;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W  = $clog2(lpsa_pkg::ID_W);

    logic [lpsa_pkg::ID_W-1:0]   id_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CW-1:0]               size_reg;
    logic [CW-1:0]               pos_reg;     // remainder during divide, then probe position
    logic [CW-1:0]               remain_reg;  // slots still to examine
    logic [ROW_W-1:0]            clr_row_reg;
    logic [lpsa_pkg::SLOT_W-1:0] res_slot_reg;
    logic                        res_full_reg;
    logic                        out_valid_reg;
    logic [lpsa_pkg::SLOT_W-1:0] out_slot_reg;
    logic                        out_full_reg;

    logic [CW-1:0]               eff_size;
    logic [CW:0]                 rem_sh;
    logic [CW-1:0]               rem_next;

    logic [lpsa_pkg::WORD_W-1:0] rd_word;
    logic [lpsa_pkg::WORD_W-1:0] cand;
    logic [lpsa_pkg::WORD_SH-1:0] off;
    logic [lpsa_pkg::WORD_SH-1:0] hit_bit;
    logic [CW-1:0]               left;
    logic [CW-1:0]               lim;
    logic [CW-1:0]               span;
    logic [CW-1:0]               n_adv;
    logic [CW-1:0]               pos_adv;
    logic [CW-1:0]               remain_after;
    logic [CW-1:0]               found_pos;
    logic                        hit;
    logic [ROW_W-1:0]            probe_row;

    logic                        ram_we;
    logic [ROW_W-1:0]            ram_waddr;
    logic [lpsa_pkg::WORD_W-1:0] ram_wdata;

    // clamp the configured size into 1..MAX_SLOTS
    always_comb
    begin
        if (table_size == '0)
        begin
            eff_size = CW'(1);
        end
        else if (int'(table_size) > MAX_SLOTS)
        begin
            eff_size = CW'(MAX_SLOTS);
        end
        else
        begin
            eff_size = CW'(table_size);
        end
    end

    // restoring divide step, remainder only
    assign rem_sh   = {pos_reg, id_reg[lpsa_pkg::ID_W-1]};
    assign rem_next = (rem_sh >= {1'b0, size_reg}) ? CW'(rem_sh - {1'b0, size_reg})
                                                    : CW'(rem_sh);

    assign probe_row = ROW_W'(pos_reg >> lpsa_pkg::WORD_SH);
    assign off       = pos_reg[lpsa_pkg::WORD_SH-1:0];
    assign left      = size_reg - pos_reg;
    assign lim       = (left < remain_reg) ? left : remain_reg;
    assign span      = CW'(lpsa_pkg::WORD_W) - CW'(off);
    assign n_adv     = (span < lim) ? span : lim;
    assign pos_adv   = pos_reg + n_adv;
    assign remain_after = remain_reg - n_adv;

    // free bits from the probe position on, inside the table and the probe budget
    always_comb
    begin
        int b;
        cand    = '0;
        hit_bit = '0;
        for (b = 0; b < lpsa_pkg::WORD_W; b++)
        begin
            cand[b] = !rd_word[b] && (b >= int'(off)) && ((b - int'(off)) < int'(lim));
        end
        for (b = lpsa_pkg::WORD_W - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                hit_bit = lpsa_pkg::WORD_SH'(b);
            end
        end
    end

    assign hit       = |cand;
    assign found_pos = {pos_reg[CW-1:lpsa_pkg::WORD_SH], hit_bit};

    always_comb
    begin
        if (cmd.clr_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_row_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = cmd.eval && hit;
            ram_waddr = probe_row;
            ram_wdata = rd_word | (lpsa_pkg::WORD_W'(1) << hit_bit);
        end
    end

    lpsa_ram #(
        .WIDTH (lpsa_pkg::WORD_W),
        .DEPTH (ROWS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (probe_row),
        .rdata (rd_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_row_reg   <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_row_reg <= clr_row_reg + ROW_W'(1);
            end
            if (cmd.start)
            begin
                cnt_reg <= CNT_W'(lpsa_pkg::ID_W - 1);
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            id_reg     <= request_id;
            size_reg   <= eff_size;
            remain_reg <= eff_size;
            pos_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            id_reg  <= {id_reg[lpsa_pkg::ID_W-2:0], 1'b0};
            pos_reg <= rem_next;
        end
        else if (cmd.eval)
        begin
            if (hit)
            begin
                res_slot_reg <= lpsa_pkg::SLOT_W'(found_pos);
                res_full_reg <= 1'b0;
            end
            else
            begin
                pos_reg      <= (pos_adv >= size_reg) ? '0 : pos_adv;
                remain_reg   <= remain_after;
                res_slot_reg <= '0;
                res_full_reg <= 1'b1;
            end
        end
        if (cmd.load_out)
        begin
            out_slot_reg <= res_slot_reg;
            out_full_reg <= res_full_reg;
        end
    end

    assign st.clr_last  = (clr_row_reg == ROW_W'(ROWS - 1));
    assign st.div_last  = (cnt_reg == '0);
    assign st.hit       = hit;
    assign st.exhausted = !hit && (remain_after == '0);
    assign st.out_busy  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_slot  = out_slot_reg;
    assign out_full  = out_full_reg;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// testbench for linear_probe_slot_allocator: random and corner requests over many table
// sizes, with each allocation predicted from a private bitmap and checked in order
// depends on lpsa_pkg and the allocator rtl

module testbench;

    localparam int SLOTS         = 8192;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 64;
    localparam int RANDOM_ITEMS  = 900;
    localparam logic [lpsa_pkg::APB_ADDR_W-1:0] TABLE_SIZE_ADDR =
        {lpsa_pkg::REG_TABLE_SIZE, 2'b00};

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [lpsa_pkg::SLOT_W-1:0] slot;
        logic                        table_full;
    } alloc_t;

    class slot_scoreboard;
        bit                         occupied [SLOTS];
        logic [lpsa_pkg::CFG_W-1:0] table_size;
        logic [lpsa_pkg::CFG_W-1:0] taken_count;
        alloc_t                     expected_allocs [$];
        int                         errors;

        function new();
            table_size  = lpsa_pkg::TABLE_SIZE_RESET;
            taken_count = '0;
            errors      = 0;
            foreach (occupied[i])
                occupied[i] = 1'b0;
        endfunction

        function int unsigned effective_size();
            if (table_size == 0)
                return 1;
            if (table_size > SLOTS)
                return SLOTS;
            return 32'(table_size);
        endfunction

        // claim the first free slot at or after the home slot, wrapping at the size in use
        function void predict_allocation(logic [lpsa_pkg::ID_W-1:0] request_id);
            int unsigned size;
            int unsigned pos;
            alloc_t      result;
            size              = effective_size();
            pos               = request_id % size;
            result.slot       = '0;
            result.table_full = 1'b1;
            for (int unsigned tries = 0; tries < size && result.table_full; tries++)
            begin
                if (!occupied[pos])
                begin
                    occupied[pos] = 1'b1;
                    if (taken_count != '1)
                        taken_count++;
                    result.slot       = pos[lpsa_pkg::SLOT_W-1:0];
                    result.table_full = 1'b0;
                end
                else
                begin
                    pos = (pos + 1 >= size) ? 0 : pos + 1;
                end
            end
            expected_allocs.push_back(result);
        endfunction

        task report(string what);
            errors++;
            $display("%0t mismatch: %s", $time, what);
        endtask

        task check_result(logic [lpsa_pkg::SLOT_W-1:0] slot, logic table_full);
            alloc_t want;
            if (expected_allocs.size() == 0)
            begin
                report($sformatf("result with no request pending: slot %0d full %0b",
                                 slot, table_full));
            end
            else
            begin
                want = expected_allocs.pop_front();
                if (slot !== want.slot)
                    report($sformatf("slot %0d, want %0d", slot, want.slot));
                if (table_full !== want.table_full)
                    report($sformatf("table_full %0b, want %0b", table_full,
                                     want.table_full));
            end
        endtask
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [30:0] request_id, [31] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [12:0] slot, [15:13] zero
    logic [0:0]  m_axis_tuser;         // [0] table_full
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [lpsa_pkg::APB_ADDR_W-1:0] paddr  = '0;
    logic [lpsa_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [lpsa_pkg::APB_DATA_W-1:0] prdata;
    logic        pready;

    int unsigned    send_idle  = 0;
    int unsigned    recv_stall = 0;
    slot_scoreboard sb;

    linear_probe_slot_allocator #(
        .MAX_SLOTS(SLOTS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // result side: check on acceptance, then choose next cycle's ready
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[lpsa_pkg::SLOT_W-1:0], m_axis_tuser[0]);
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle = 0;  recv_stall = 0;  end
            IDLE_SENDER:   begin send_idle = 65; recv_stall = 0;  end
            IDLE_RECEIVER: begin send_idle = 0;  recv_stall = 65; end
            default:       begin send_idle = 16; recv_stall = 16; end
        endcase
    endtask

    // setup then access; psel is left high so a second access can follow directly
    task automatic apb_access(input logic wr, input logic [lpsa_pkg::APB_ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
    endtask

    task automatic set_table_size(input logic [31:0] value);
        logic [31:0] readback;
        apb_access(1'b1, TABLE_SIZE_ADDR, value, readback);
        sb.table_size = value[lpsa_pkg::CFG_W-1:0];
        apb_access(1'b0, TABLE_SIZE_ADDR, '0, readback);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== 32'(value[lpsa_pkg::CFG_W-1:0]))
            sb.report($sformatf("table_size reads %0d, want %0d", readback,
                                value[lpsa_pkg::CFG_W-1:0]));
    endtask

    // valid is lowered here only while idling, so a back-to-back request keeps it high
    task automatic send_request(input logic [lpsa_pkg::ID_W-1:0] request_id);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, request_id};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.predict_allocation(request_id);
    endtask

    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        while (sb.expected_allocs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mix of fixed corner ids, fully random ids and ids whose home slot lands in
    // the crowded low slots or near the wrap point
    function automatic logic [lpsa_pkg::ID_W-1:0] pick_request_id(int unsigned size);
        int unsigned pick;
        int unsigned home;
        int unsigned mult;
        longint      id;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            id = 0;
        else if (pick < 10)
            id = 64'h7FFF_FFFF;
        else if (pick < 45)
            id = $urandom & 32'h7FFF_FFFF;
        else
        begin
            if (pick < 80)
                home = $urandom_range(0, (size > 64) ? 63 : size - 1);
            else
                home = size - 1 - $urandom_range(0, (size > 8) ? 7 : size - 1);
            mult = $urandom_range(0, (32'h7FFF_FFFF - home) / size);
            id   = longint'(home) + longint'(mult) * longint'(size);
        end
        return id[lpsa_pkg::ID_W-1:0];
    endfunction

    initial
    begin
        int unsigned size_corners [12];
        logic [31:0] readback;
        int unsigned size_value;
        int unsigned eff;
        int unsigned count;
        int          sent;
        int          phase;

        size_corners = '{3, 64, 65, 257, 8191, 2, 1000, 8193, 0, 4096, 16383, 1};
        sb = new();
        set_idle(IDLE_NONE);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        apb_access(1'b0, TABLE_SIZE_ADDR, '0, readback);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== 32'(lpsa_pkg::TABLE_SIZE_RESET))
            sb.report($sformatf("table_size after reset reads %0d", readback));

        // full size: collisions on slot 0, top slot, wrap past the end
        send_request(31'd0);
        send_request(31'd0);
        send_request(31'h7FFF_FFFF);
        send_request(31'h7FFF_FFFF);
        send_request(31'd8191);

        // size zero acts as one slot, already taken
        wait_drained;
        set_table_size(32'd0);
        send_request(31'd5);
        wait_drained;
        set_table_size(32'd1);
        send_request(31'h7FFF_FFFF);

        // above capacity clamps to the full table
        wait_drained;
        set_table_size(32'd16383);
        send_request(31'd4096);
        send_request(31'h2AAA_AAAA);
        send_request(31'd32767);

        // shrink over taken slots, upper write bits ignored, requests find the table full
        wait_drained;
        set_table_size(32'hFFFF_C005);
        send_request(31'd7);
        send_request(31'd9);

        // row boundaries of the bitmap
        wait_drained;
        set_table_size(32'd32);
        send_request(31'd31);
        send_request(31'd31);
        wait_drained;
        set_table_size(32'd33);
        send_request(31'd32);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase < 12)
                size_value = size_corners[phase];
            else if ($urandom_range(0, 3) == 0)
                size_value = $urandom_range(2, 48);
            else
                size_value = $urandom_range(49, 16383);
            wait_drained;
            set_table_size(($urandom & 32'hFFFF_C000) | size_value);
            set_idle(idle_mode_t'(phase % 4));
            eff = sb.effective_size();
            // small tables get a few more requests than slots so they run full
            count = (eff <= 48) ? eff + $urandom_range(1, 4) : $urandom_range(25, 70);
            repeat (count)
            begin
                send_request(pick_request_id(eff));
                sent++;
            end
            phase++;
        end

        wait_drained;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.expected_allocs.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_allocs.size()));
        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #(30_000_000);
        $display("testbench: done, errors");
        $finish;
    end

endmodule
